### design/crnp_pkg.sv
package crnp_pkg;

  // Result codes carried on the result channel's tuser
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_DIGIT = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BAD_END  = 2'd3
  } crnp_status_t;

  // base_select register codes
  localparam logic BASE_HEX = 1'b0;
  localparam logic BASE_DEC = 1'b1;

  localparam int unsigned ValW  = 64;
  localparam int unsigned CharW = 8;
  // Product plus digit needs four guard bits above the value
  localparam int unsigned SumW  = ValW + 4;

  // Characters that may legally end a number
  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_LF    = 8'h0A;
  localparam logic [CharW-1:0] CH_CR    = 8'h0D;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_COMMA = 8'h2C;
  localparam logic [CharW-1:0] CH_SLASH = 8'h2F;
  localparam logic [CharW-1:0] CH_SEMI  = 8'h3B;

  localparam logic [CharW-1:0] CH_0  = 8'h30;
  localparam logic [CharW-1:0] CH_9  = 8'h39;
  localparam logic [CharW-1:0] CH_LA = 8'h61;
  localparam logic [CharW-1:0] CH_LF_HEX = 8'h66;
  localparam logic [CharW-1:0] CH_UA = 8'h41;
  localparam logic [CharW-1:0] CH_UF = 8'h46;

  // Outcome of one character, handed from the step logic to the top level
  typedef struct packed {
    logic              emit;
    crnp_status_t      status;
    logic [ValW-1:0]   value;
    logic [ValW-1:0]   acc_nxt;
    logic              in_number_nxt;
  } crnp_step_t;

endpackage

### design/checked_reference_number_parser.sv
// out_tvalid rises once the character that ends or breaks the number has passed the
// input stage and the result register; a new result waits while the last is not taken.
// Throughput: one character per cycle while results are taken; the accumulator
// multiply-add and its overflow check are combinational, feeding the next character.
// Reset (rst_n low, synchronous): accumulator cleared, no number in progress,
// base_select set to hexadecimal, both stages empty.
module checked_reference_number_parser (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: base_select (0 hex, 1 decimal)
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // character stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] start_req
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] value, [71:64] end_char
  output logic [1:0]  out_tuser   // [1:0] status
);
  import crnp_pkg::*;

  logic            base_select_r;

  // Input stage
  logic            s1_valid_r, s1_valid_nxt;
  logic [7:0]      s1_ch_r;
  logic            s1_start_r;

  // Parser state
  logic [ValW-1:0] acc_r;
  logic            in_number_r;

  // Result register
  logic            out_valid_r, out_valid_nxt;
  crnp_status_t    out_status_r;
  logic [ValW-1:0] out_value_r;
  logic [7:0]      out_char_r;

  crnp_step_t      step;
  logic            proc;
  logic            in_fire;
  logic            out_fire;

  crnp_step u_step (
    .ch          (s1_ch_r),
    .start_req   (s1_start_r),
    .base_select (base_select_r),
    .in_number   (in_number_r),
    .acc         (acc_r),
    .step        (step)
  );

  // Process the held character unless it makes a result that has nowhere to go
  assign out_fire  = out_valid_r && out_tready;
  assign proc      = s1_valid_r && (!step.emit || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || proc;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (proc) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (proc && step.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_select_r <= BASE_HEX;
      s1_valid_r    <= 1'b0;
      acc_r         <= '0;
      in_number_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_select_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // advance the parser state only when the held character is consumed
      if (proc) begin
        acc_r       <= step.acc_nxt;
        in_number_r <= step.in_number_nxt;
      end
    end
  end

  // Payload registers: hold until replaced
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r    <= in_tdata;
      s1_start_r <= in_tuser;
    end
    if (proc && step.emit) begin
      out_status_r <= step.status;
      out_value_r  <= step.value;
      out_char_r   <= s1_ch_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_char_r, out_value_r};
  assign out_tuser  = out_status_r;

endmodule

### design/crnp_step.sv
module crnp_step (
  input  logic [7:0]          ch,
  input  logic                start_req,
  input  logic                base_select,
  input  logic                in_number,
  input  logic [63:0]         acc,
  output crnp_pkg::crnp_step_t step
);
  import crnp_pkg::*;

  logic              is_digit;
  logic [3:0]        digit;
  logic              is_ending;
  logic [ValW-1:0]   acc_eff;
  logic [SumW-1:0]   acc_ext;
  logic [SumW-1:0]   prod;
  logic [SumW-1:0]   sum;
  logic              ovf;

  // Decode the character as a digit of the selected base
  always_comb begin
    is_digit = 1'b0;
    digit    = 4'd0;
    if (ch >= CH_0 && ch <= CH_9) begin
      is_digit = 1'b1;
      digit    = 4'(ch - CH_0);
    end else if (base_select == BASE_HEX && ch >= CH_LA && ch <= CH_LF_HEX) begin
      is_digit = 1'b1;
      digit    = 4'(ch - CH_LA + 8'd10);
    end else if (base_select == BASE_HEX && ch >= CH_UA && ch <= CH_UF) begin
      is_digit = 1'b1;
      digit    = 4'(ch - CH_UA + 8'd10);
    end
  end

  assign is_ending = (ch == CH_NUL) || (ch == CH_SPACE) || (ch == CH_TAB) ||
                     (ch == CH_CR) || (ch == CH_LF) || (ch == CH_COMMA) ||
                     (ch == CH_SEMI) || (ch == CH_SLASH);

  // acc * base + digit, kept wide so any carry past 64 bits shows overflow
  assign acc_eff = start_req ? '0 : acc;
  assign acc_ext = {4'b0, acc_eff};
  assign prod    = (base_select == BASE_HEX) ? (acc_ext << 4)
                                             : ((acc_ext << 3) + (acc_ext << 1));
  assign sum     = prod + {{(SumW-4){1'b0}}, digit};
  assign ovf     = |sum[SumW-1:ValW];

  always_comb begin
    step.emit          = 1'b0;
    step.status        = ST_OK;
    step.value         = '0;
    step.acc_nxt       = acc;
    step.in_number_nxt = in_number;
    priority if (!start_req && !in_number) begin
      // idle character: ignore
    end else if (is_digit && ovf) begin
      step.emit          = 1'b1;
      step.status        = ST_OVERFLOW;
      step.acc_nxt       = '0;
      step.in_number_nxt = 1'b0;
    end else if (is_digit) begin
      step.acc_nxt       = sum[ValW-1:0];
      step.in_number_nxt = 1'b1;
    end else if (start_req) begin
      step.emit          = 1'b1;
      step.status        = ST_NO_DIGIT;
      step.acc_nxt       = '0;
      step.in_number_nxt = 1'b0;
    end else if (is_ending) begin
      step.emit          = 1'b1;
      step.status        = ST_OK;
      step.value         = acc;
      step.acc_nxt       = '0;
      step.in_number_nxt = 1'b0;
    end else begin
      step.emit          = 1'b1;
      step.status        = ST_BAD_END;
      step.acc_nxt       = '0;
      step.in_number_nxt = 1'b0;
    end
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crnp_pkg::*;

  // Cycles without any transaction on either channel before the run is abandoned.
  // The slowest legal stretch is an input gap, a result stall, the pipeline and the
  // pause before a register write.
  localparam int unsigned StallLimit = 1000;

  // Pipeline depth from the head of the block, plus margin, used before register
  // writes and at the end of the run
  localparam int unsigned SettleCycles = 4;

  // Per-phase character budget for the random text, six phases in all
  localparam int unsigned PhaseChars = 130;

  typedef struct {
    crnp_status_t    status;
    logic [63:0]     value;
    logic [7:0]      end_char;
  } number_result_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;   // [7:0] ch
  logic        in_tuser    = 1'b0; // [0] start_req
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [71:0] out_tdata;          // [63:0] value, [71:64] end_char
  logic [1:0]  out_tuser;          // [1:0] status

  // Shadow of the parser state, advanced on every accepted character
  logic [63:0] acc_shadow       = '0;
  logic        in_number_shadow = 1'b0;
  logic        base_shadow      = BASE_HEX;

  number_result_t expected_numbers[$];

  int unsigned parsed_chars = 0;  // characters that were not ignored
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  bit          no_idle      = 1'b0;

  logic [7:0] terminators [0:7] = '{CH_NUL, CH_TAB, CH_LF, CH_CR,
                                    CH_SPACE, CH_COMMA, CH_SLASH, CH_SEMI};

  checked_reference_number_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5ns clk = ~clk;

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------

  // Digit value of c in the selected base, or -1 when c is no digit there
  function automatic int digit_val(logic [7:0] c, logic dec);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (!dec && c >= CH_LA && c <= CH_LF_HEX) return int'(c - CH_LA) + 10;
    if (!dec && c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic bit is_terminator(logic [7:0] c);
    case (c)
      CH_NUL, CH_TAB, CH_LF, CH_CR, CH_SPACE, CH_COMMA, CH_SLASH, CH_SEMI: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Random digit of the selected base; hex letters come in either case
  function automatic logic [7:0] rand_digit(logic dec);
    int v;
    v = dec ? $urandom_range(0, 9) : $urandom_range(0, 15);
    if (v < 10) return CH_0 + 8'(v);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10);
  endfunction

  // ---------------------------------------------------------------------------
  // Parser prediction
  // ---------------------------------------------------------------------------

  // Queue one result and drop back to waiting for a start
  task automatic close_number(input crnp_status_t st, input logic [63:0] val,
                              input logic [7:0] ch);
    number_result_t r;
    r.status   = st;
    r.value    = val;
    r.end_char = ch;
    expected_numbers.insert(expected_numbers.size(), r);
    acc_shadow       = '0;
    in_number_shadow = 1'b0;
  endtask

  task automatic advance_parser(input logic [7:0] ch, input logic start);
    int          d;
    logic [63:0] radix;
    logic [63:0] headroom;
    // Outside a number, characters without a start are dropped silently
    if (!start && !in_number_shadow) return;
    parsed_chars++;
    if (start) begin
      // A start abandons whatever was being accumulated
      acc_shadow       = '0;
      in_number_shadow = 1'b1;
    end
    radix = (base_shadow == BASE_DEC) ? 64'd10 : 64'd16;
    d     = digit_val(ch, base_shadow == BASE_DEC);
    if (d < 0) begin
      if (start) close_number(ST_NO_DIGIT, '0, ch);
      else if (is_terminator(ch)) close_number(ST_OK, acc_shadow, ch);
      else close_number(ST_BAD_END, '0, ch);
    end else begin
      // Refuse the digit if acc * radix + d would not fit in 64 bits
      headroom = (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / radix;
      if (acc_shadow > headroom) close_number(ST_OVERFLOW, '0, ch);
      else acc_shadow = acc_shadow * radix + 64'(d);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: register writes, accepted characters and results, all sampled
  // at the rising edge in one process so the order within a step is fixed
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    number_result_t want;
    if (!rst_n) begin
      acc_shadow       = '0;
      in_number_shadow = 1'b0;
      base_shadow      = BASE_HEX;
      idle_cycles      = 0;
    end else begin
      if (cfg_wr_en) base_shadow = cfg_wr_data;
      if (in_tvalid && in_tready) advance_parser(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (expected_numbers.size() == 0) begin
          $error("unexpected result: status %0d value %h end_char %h",
                 out_tuser, out_tdata[63:0], out_tdata[71:64]);
          mismatches++;
        end else begin
          want = expected_numbers.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tuser);
            mismatches++;
          end
          if (out_tdata[63:0] !== want.value) begin
            $error("value: expected %h, actual %h", want.value, out_tdata[63:0]);
            mismatches++;
          end
          if (out_tdata[71:64] !== want.end_char) begin
            $error("end_char: expected %h, actual %h", want.end_char, out_tdata[71:64]);
            mismatches++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Result side: hold tready low for a random stall before each transaction
  initial begin : result_sink
    int stall;
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        out_tready <= 1'b0;
        @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Abandon the run when nothing moves for too long
  initial begin : watchdog
    while (idle_cycles < StallLimit) @(posedge clk);
    $display("checked_reference_number_parser test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; all of them are entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // Offer one character after a random gap and hold it until the transaction
  task automatic send_char(input logic [7:0] ch, input logic start);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Send a word whose first character carries the start flag
  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
  endtask

  // Stop offering characters and wait until every queued result is back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_numbers.size() != 0) @(negedge clk);
  endtask

  // Write base_select with the block idle; close any open number first
  task automatic set_base(input logic b);
    if (in_number_shadow) send_char(CH_NUL, 1'b0);
    wait_results_drained();
    // An ignored last character makes no result but may still be in the pipe
    repeat (SettleCycles) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hexadecimal straight out of reset: all digit ranges, every outcome but overflow
  task automatic test_hex_basics();
    send_string("0aF9 ");           // digits of both cases, ended by a space
    send_string("g");               // first character is no digit
    send_char(CH_NUL, 1'b1);        // NUL as first character is no digit either
    send_char("x", 1'b0);           // idle character, dropped
    send_string("1");               // left open ...
    send_string("A;");              // ... and abandoned by a fresh start
    send_string("fz");              // bad ending character
    send_char("b", 1'b1);
    send_char(8'hFF, 1'b0);         // top bit of ch as a bad ending
  endtask

  // Decimal: hex letters lose their meaning
  task automatic test_dec_basics();
    set_base(BASE_DEC);
    send_string("a");
    send_string("9A");
    send_string("7/");
  endtask

  // Random text over several base settings, with and without idling
  task automatic test_random_text();
    logic [7:0]  run[$];
    logic        dec;
    int          kind;
    int          len;
    int unsigned goal;
    int unsigned half;
    bit          paused;
    string       max_dec;
    max_dec = "18446744073709551615";
    for (int phase = 0; phase < 6; phase++) begin
      set_base((phase == 1 || phase == 2 || phase == 4) ? BASE_DEC : BASE_HEX);
      // Two middle phases run back to back on both channels
      no_idle = (phase == 2 || phase == 3);
      goal    = parsed_chars + PhaseChars;
      half    = parsed_chars + PhaseChars / 2;
      paused  = 1'b0;
      while (parsed_chars < goal) begin
        // Hold the input once per phase until the results have caught up
        if (!paused && parsed_chars >= half) begin
          wait_results_drained();
          paused = 1'b1;
        end
        dec  = (base_shadow == BASE_DEC);
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
          // Noise: any byte, start flag at random
          repeat ($urandom_range(1, 4))
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          run.delete();
          if (kind < 30) begin
            // Numbers around the 64-bit ceiling
            if (dec) begin
              for (int i = 0; i < 19; i++) run.insert(run.size(), max_dec[i]);
              run.insert(run.size(), rand_digit(1'b1));
            end else if ($urandom_range(0, 1)) begin
              repeat (16) run.insert(run.size(), $urandom_range(0, 1) ? CH_LF_HEX : CH_UF);
            end else begin
              run.insert(run.size(), CH_0 + 8'd1);
              repeat (15) run.insert(run.size(), CH_0);
            end
            if ($urandom_range(0, 2) == 0) run.insert(run.size(), rand_digit(dec));
          end else begin
            len = ($urandom_range(0, 6) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 22);
            repeat (len) run.insert(run.size(), rand_digit(dec));
          end
          // Close with a terminator, a stray character, or nothing at all so
          // that the next start abandons the number
          kind = $urandom_range(0, 19);
          if (kind < 15) begin
            run.insert(run.size(), terminators[$urandom_range(0, 7)]);
          end else if (kind < 18) begin
            run.insert(run.size(), 8'($urandom_range(0, 255)));
            while (digit_val(run[$], dec) >= 0 || is_terminator(run[$]))
              run[$] = 8'($urandom_range(0, 255));
          end
          foreach (run[i]) send_char(run[i], i == 0);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_hex_basics();
    test_dec_basics();
    test_random_text();
    wait_results_drained();
    // Leave room for any stray result to show up
    repeat (SettleCycles + 2) @(negedge clk);
    if (mismatches == 0) begin
      $display("checked_reference_number_parser test passed");
    end else begin
      $display("checked_reference_number_parser test failed");
    end
    $finish;
  end

endmodule
